// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the heightfield grid ray walk RTL.
// Included by the top level; needs a clock aclk and a reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HGRW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define HGRW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/hgrw_pkg.sv =====
// Package for the heightfield grid ray walk: sequencer states, widths, constants
// and saturation helpers. Depends on nothing.
`default_nettype none
package hgrw_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MPX,
        ST_MPZ,
        ST_MDX,
        ST_MDZ,
        ST_SQX,
        ST_SQZ,
        ST_ROOT,
        ST_AXSEL,
        ST_DINC,
        ST_MCRS,
        ST_DCRS,
        ST_FIX,
        ST_MKLO,
        ST_MKHI,
        ST_APPLY,
        ST_WALK
    } state_t;

    localparam logic [2:0] REG_OFFSET_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_Z   = 3'd1;
    localparam logic [2:0] REG_CELL_SCALE = 3'd2;
    localparam logic [2:0] REG_GRID_WIDTH = 3'd3;
    localparam logic [2:0] REG_GRID_DEPTH = 3'd4;

    localparam int POS_W  = 54;
    localparam int FC_W   = POS_W - 32;
    localparam int AX_W   = 37;
    localparam int FLAT_W = 38;
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W  = 54;
    localparam int KM_W   = 24;
    localparam int CNT_W  = 6;

    localparam logic signed [63:0] INF_Q    = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] DIST_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic [CNT_W-1:0]   CNT_LAST = 6'd63;

    function automatic logic signed [63:0] sat_inf(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > INF_Q) begin
            r = INF_Q;
        end else if (v < -INF_Q) begin
            r = -INF_Q;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [30:0] clamp_dist(input logic signed [63:0] v);
        logic [30:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > DIST_MAX) begin
            r = '1;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hgrw_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used by the heightfield grid ray walk top level; no package needed.
`default_nettype none
module hgrw_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 37
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int IT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   rs;
    logic             qb;

    always_comb begin
        busy_next = busy_reg;
        it_next   = it_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rs = {rem_reg, num_reg[NUM_W-1]};
        qb = (rs >= {1'b0, den_reg});
        if (start) begin
            busy_next = 1'b1;
            it_next   = IT_W'(NUM_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = qb ? DEN_W'(rs - {1'b0, den_reg}) : rs[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], qb};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            it_next  = it_reg - 1'b1;
            if (it_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        it_reg  <= it_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/heightfield_grid_ray_walk_unit.sv =====
// Heightfield grid ray walk: per-segment setup sequencer and cell walker.
// Depends on hgrw_pkg, hgrw_div and assert_macros.svh.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | s_tdata 192b segment
//  m_      | out | m_tvalid/tready  | m_tdata 72b cell, m_tlast
//  cfg_    | in  | cfg_valid/ready  | cfg_index 3b, cfg_data 32b
//
// Setup runs four multiplies, two squares, a bit-serial square root and per axis
// up to two divisions on the shared divider.
// Then one cell per cycle while m_tready is high; up to 64 cells per segment.
// s_tready is high only between segments; a held result does not block accept.
// Reset is synchronous; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module heightfield_grid_ray_walk_unit #(
    parameter int MAX_GRID = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // begin_x, begin_y, begin_z, end_x, end_y, end_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // cell_x[4:0], cell_z[9:5], enter_dist, exit_dist
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int SZ_W   = $clog2(MAX_GRID + 1);
    localparam int CELL_W = $clog2(MAX_GRID) + 2;

    hgrw_pkg::state_t state_reg, state_next;

    logic signed [31:0] offx_reg, offz_reg;
    logic [19:0]        cs_reg;
    logic [5:0]         gw_reg, gd_reg;

    logic signed [32:0] sumx_reg, sumz_reg, dx_reg, dz_reg;
    logic signed [32:0] sumx_next, sumz_next, dx_next, dz_next;
    logic signed [hgrw_pkg::POS_W-1:0] px_reg, pz_reg, px_next, pz_next;
    logic [hgrw_pkg::AX_W-1:0] ax_reg, az_reg, ax_next, az_next;
    logic [62:0] sq_reg, sq_next;
    logic [63:0] rad_reg, rad_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  it_reg, it_next;
    logic [hgrw_pkg::FLAT_W-1:0] flat_reg, flat_next;
    logic        axis_reg, axis_next;
    logic signed [63:0] inc_reg [2];
    logic signed [63:0] inc_next [2];
    logic signed [63:0] crs_reg [2];
    logic signed [63:0] crs_next [2];
    logic signed [1:0]  stp_reg [2];
    logic signed [1:0]  stp_next [2];
    logic signed [CELL_W-1:0] cell_reg [2];
    logic signed [CELL_W-1:0] cell_next [2];
    logic [hgrw_pkg::KM_W-1:0] kmag_reg, kmag_next;
    logic        kneg_reg, kneg_next;
    logic [hgrw_pkg::MUL_P_W-1:0] plo_reg, plo_next, phi_reg, phi_next;
    logic signed [63:0] dist_reg, dist_next;
    logic [hgrw_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    logic [hgrw_pkg::MUL_A_W-1:0] mul_a;
    logic [hgrw_pkg::MUL_B_W-1:0] mul_b;
    logic [hgrw_pkg::MUL_P_W-1:0] prod;

    logic        div_start, div_busy;
    logic [hgrw_pkg::NUM_W-1:0] div_num, div_quo;

    logic [SZ_W-1:0] w_eff, d_eff, size_sel;
    logic [hgrw_pkg::AX_W-1:0] mag_sel, mmax;
    logic signed [hgrw_pkg::POS_W-1:0] pos_sel;
    logic        dneg_sel;
    logic [2:0]  sh;
    logic [30:0] axs, azs;
    logic [34:0] rs;
    logic [34:0] trial;
    logic [15:0] d16;
    logic [31:0] nfrac;
    logic signed [hgrw_pkg::FC_W-1:0] fc0;
    logic signed [hgrw_pkg::FC_W:0]   fc_adj;
    logic signed [hgrw_pkg::FC_W+1:0] st, kval, smax;
    logic [101:0] ktot;
    logic signed [63:0] mterm;
    logic        accept, walk_go, take_x, stop, zero_seg;
    logic signed [CELL_W-1:0] x_nx, z_nx;
    logic signed [63:0] dnew, dout, flen;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == hgrw_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign walk_go   = (state_reg == hgrw_pkg::ST_WALK) && (!m_tvalid_reg || m_tready);
    assign zero_seg  = (s_tdata[127:96] == s_tdata[31:0]) &&
                       (s_tdata[159:128] == s_tdata[63:32]) &&
                       (s_tdata[191:160] == s_tdata[95:64]);

    always_comb begin
        if ({26'd0, gw_reg} < 32'd2) begin
            w_eff = SZ_W'(2);
        end else if ({26'd0, gw_reg} > MAX_GRID) begin
            w_eff = SZ_W'(MAX_GRID);
        end else begin
            w_eff = SZ_W'(gw_reg);
        end
        if ({26'd0, gd_reg} < 32'd2) begin
            d_eff = SZ_W'(2);
        end else if ({26'd0, gd_reg} > MAX_GRID) begin
            d_eff = SZ_W'(MAX_GRID);
        end else begin
            d_eff = SZ_W'(gd_reg);
        end
    end

    assign mag_sel  = axis_reg ? az_reg : ax_reg;
    assign pos_sel  = axis_reg ? pz_reg : px_reg;
    assign dneg_sel = axis_reg ? dz_reg[32] : dx_reg[32];
    assign size_sel = axis_reg ? d_eff : w_eff;
    assign mmax     = (ax_reg > az_reg) ? ax_reg : az_reg;
    assign flen     = 64'(flat_reg);

    always_comb begin
        sh = 3'd6;
        for (int i = 6; i >= 0; i--) begin
            if ((mmax >> i) < (hgrw_pkg::AX_W'(1) << 31)) begin
                sh = 3'(i);
            end
        end
    end

    assign axs   = 31'(ax_reg >> sh);
    assign azs   = 31'(az_reg >> sh);
    assign nfrac = 32'(~pos_sel[31:0] + 32'd1);
    assign d16   = dneg_sel ? pos_sel[31:16] : nfrac[31:16];

    always_comb begin
        unique case (state_reg)
            hgrw_pkg::ST_MPX: begin
                mul_a = hgrw_pkg::MUL_A_W'(sumx_reg[32] ? -sumx_reg : sumx_reg);
                mul_b = {12'd0, cs_reg};
            end
            hgrw_pkg::ST_MPZ: begin
                mul_a = hgrw_pkg::MUL_A_W'(sumz_reg[32] ? -sumz_reg : sumz_reg);
                mul_b = {12'd0, cs_reg};
            end
            hgrw_pkg::ST_MDX: begin
                mul_a = hgrw_pkg::MUL_A_W'(dx_reg[32] ? -dx_reg : dx_reg);
                mul_b = {12'd0, cs_reg};
            end
            hgrw_pkg::ST_MDZ: begin
                mul_a = hgrw_pkg::MUL_A_W'(dz_reg[32] ? -dz_reg : dz_reg);
                mul_b = {12'd0, cs_reg};
            end
            hgrw_pkg::ST_SQX: begin
                mul_a = hgrw_pkg::MUL_A_W'(axs);
                mul_b = {1'b0, axs};
            end
            hgrw_pkg::ST_SQZ: begin
                mul_a = hgrw_pkg::MUL_A_W'(azs);
                mul_b = {1'b0, azs};
            end
            hgrw_pkg::ST_MCRS: begin
                mul_a = flat_reg;
                mul_b = {16'd0, d16};
            end
            hgrw_pkg::ST_MKLO: begin
                mul_a = hgrw_pkg::MUL_A_W'(kmag_reg);
                mul_b = inc_reg[axis_reg][31:0];
            end
            hgrw_pkg::ST_MKHI: begin
                mul_a = hgrw_pkg::MUL_A_W'(kmag_reg);
                mul_b = inc_reg[axis_reg][63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = hgrw_pkg::MUL_P_W'(mul_a) * hgrw_pkg::MUL_P_W'(mul_b);

    assign div_start = ((state_reg == hgrw_pkg::ST_AXSEL) && (mag_sel != '0)) ||
                       (state_reg == hgrw_pkg::ST_MCRS);
    assign div_num   = (state_reg == hgrw_pkg::ST_MCRS) ? prod[hgrw_pkg::NUM_W-1:0]
                                                        : {flat_reg, 16'd0};

    hgrw_div #(
        .NUM_W(hgrw_pkg::NUM_W),
        .DEN_W(hgrw_pkg::AX_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (mag_sel),
        .busy   (div_busy),
        .quo    (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hgrw_pkg::ST_IDLE: begin
                if (accept && !zero_seg) begin
                    state_next = hgrw_pkg::ST_MPX;
                end
            end
            hgrw_pkg::ST_MPX:  state_next = hgrw_pkg::ST_MPZ;
            hgrw_pkg::ST_MPZ:  state_next = hgrw_pkg::ST_MDX;
            hgrw_pkg::ST_MDX:  state_next = hgrw_pkg::ST_MDZ;
            hgrw_pkg::ST_MDZ:  state_next = hgrw_pkg::ST_SQX;
            hgrw_pkg::ST_SQX:  state_next = hgrw_pkg::ST_SQZ;
            hgrw_pkg::ST_SQZ:  state_next = hgrw_pkg::ST_ROOT;
            hgrw_pkg::ST_ROOT: begin
                if (it_reg == '0) begin
                    state_next = hgrw_pkg::ST_AXSEL;
                end
            end
            hgrw_pkg::ST_AXSEL: begin
                state_next = (mag_sel == '0) ? hgrw_pkg::ST_FIX : hgrw_pkg::ST_DINC;
            end
            hgrw_pkg::ST_DINC: begin
                if (!div_busy) begin
                    state_next = hgrw_pkg::ST_MCRS;
                end
            end
            hgrw_pkg::ST_MCRS: state_next = hgrw_pkg::ST_DCRS;
            hgrw_pkg::ST_DCRS: begin
                if (!div_busy) begin
                    state_next = hgrw_pkg::ST_FIX;
                end
            end
            hgrw_pkg::ST_FIX:  state_next = hgrw_pkg::ST_MKLO;
            hgrw_pkg::ST_MKLO: state_next = hgrw_pkg::ST_MKHI;
            hgrw_pkg::ST_MKHI: state_next = hgrw_pkg::ST_APPLY;
            hgrw_pkg::ST_APPLY: begin
                state_next = axis_reg ? hgrw_pkg::ST_WALK : hgrw_pkg::ST_AXSEL;
            end
            hgrw_pkg::ST_WALK: begin
                if (walk_go && (stop || cnt_reg == hgrw_pkg::CNT_LAST)) begin
                    state_next = hgrw_pkg::ST_IDLE;
                end
            end
            default: state_next = hgrw_pkg::ST_IDLE;
        endcase
    end

    // walk step
    always_comb begin
        take_x = crs_reg[0] < crs_reg[1];
        x_nx   = cell_reg[0];
        z_nx   = cell_reg[1];
        if (take_x) begin
            x_nx = cell_reg[0] + CELL_W'(stp_reg[0]);
            dnew = crs_reg[0];
        end else begin
            z_nx = cell_reg[1] + CELL_W'(stp_reg[1]);
            dnew = crs_reg[1];
        end
        if (dnew > flen) begin
            dout = flen;
            stop = 1'b1;
        end else begin
            dout = dnew;
            stop = (x_nx < 0) || (z_nx < 0) ||
                   (x_nx >= $signed(CELL_W'(w_eff - 1'b1))) ||
                   (z_nx >= $signed(CELL_W'(d_eff - 1'b1)));
        end
    end

    // axis fix-up: integer start and clamp into the grid
    always_comb begin
        fc0    = pos_sel[hgrw_pkg::POS_W-1:32];
        fc_adj = (hgrw_pkg::FC_W + 1)'(fc0);
        if (crs_reg[axis_reg] == 0 && stp_reg[axis_reg] == -2'sd1) begin
            fc_adj = fc_adj - (hgrw_pkg::FC_W + 1)'(1);
        end
        smax = $signed((hgrw_pkg::FC_W + 2)'(size_sel)) - (hgrw_pkg::FC_W + 2)'(2);
        if (fc_adj < 0) begin
            st = '0;
        end else if ((hgrw_pkg::FC_W + 2)'(fc_adj) > smax) begin
            st = smax;
        end else begin
            st = (hgrw_pkg::FC_W + 2)'(fc_adj);
        end
        kval  = st - (hgrw_pkg::FC_W + 2)'(fc_adj);
        ktot  = {phi_reg, 32'd0} + 102'(plo_reg);
        mterm = (ktot > 102'(hgrw_pkg::INF_Q)) ? hgrw_pkg::INF_Q : ktot[63:0];
    end

    // datapath
    always_comb begin
        sumx_next = sumx_reg;
        sumz_next = sumz_reg;
        dx_next   = dx_reg;
        dz_next   = dz_reg;
        px_next   = px_reg;
        pz_next   = pz_reg;
        ax_next   = ax_reg;
        az_next   = az_reg;
        sq_next   = sq_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        it_next   = it_reg;
        flat_next = flat_reg;
        axis_next = axis_reg;
        inc_next  = inc_reg;
        crs_next  = crs_reg;
        stp_next  = stp_reg;
        cell_next = cell_reg;
        kmag_next = kmag_reg;
        kneg_next = kneg_reg;
        plo_next  = plo_reg;
        phi_next  = phi_reg;
        dist_next = dist_reg;
        cnt_next  = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        rs    = {rem_reg[32:0], rad_reg[63:62]};
        trial = {1'b0, root_reg, 2'b01};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            hgrw_pkg::ST_IDLE: begin
                sumx_next = 33'($signed(s_tdata[31:0])) + 33'(offx_reg);
                sumz_next = 33'($signed(s_tdata[95:64])) + 33'(offz_reg);
                dx_next   = 33'($signed(s_tdata[127:96])) - 33'($signed(s_tdata[31:0]));
                dz_next   = 33'($signed(s_tdata[191:160])) - 33'($signed(s_tdata[95:64]));
            end
            hgrw_pkg::ST_MPX: begin
                px_next = sumx_reg[32] ? -$signed(prod[hgrw_pkg::POS_W-1:0])
                                       : $signed(prod[hgrw_pkg::POS_W-1:0]);
            end
            hgrw_pkg::ST_MPZ: begin
                pz_next = sumz_reg[32] ? -$signed(prod[hgrw_pkg::POS_W-1:0])
                                       : $signed(prod[hgrw_pkg::POS_W-1:0]);
            end
            hgrw_pkg::ST_MDX: ax_next = prod[hgrw_pkg::AX_W+15:16];
            hgrw_pkg::ST_MDZ: az_next = prod[hgrw_pkg::AX_W+15:16];
            hgrw_pkg::ST_SQX: sq_next = prod[62:0];
            hgrw_pkg::ST_SQZ: begin
                rad_next  = 64'(sq_reg) + 64'(prod[62:0]);
                rem_next  = '0;
                root_next = '0;
                it_next   = 5'd31;
            end
            hgrw_pkg::ST_ROOT: begin
                if (rs >= trial) begin
                    rem_next  = rs - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end else begin
                    rem_next  = rs;
                    root_next = {root_reg[30:0], 1'b0};
                end
                rad_next = {rad_reg[61:0], 2'b00};
                it_next  = it_reg - 1'b1;
                flat_next = hgrw_pkg::FLAT_W'(root_next) << sh;
                axis_next = 1'b0;
            end
            hgrw_pkg::ST_AXSEL: begin
                if (mag_sel == '0) begin
                    stp_next[axis_reg] = 2'sd0;
                    inc_next[axis_reg] = hgrw_pkg::INF_Q;
                    crs_next[axis_reg] = hgrw_pkg::INF_Q;
                end else begin
                    stp_next[axis_reg] = dneg_sel ? -2'sd1 : 2'sd1;
                end
            end
            hgrw_pkg::ST_DINC: begin
                inc_next[axis_reg] = 64'(div_quo);
            end
            hgrw_pkg::ST_DCRS: begin
                crs_next[axis_reg] = 64'(div_quo);
            end
            hgrw_pkg::ST_FIX: begin
                if (crs_reg[axis_reg] == 0) begin
                    crs_next[axis_reg] = inc_reg[axis_reg];
                end
                cell_next[axis_reg] = CELL_W'(st);
                kneg_next = (stp_reg[axis_reg] < 0) ^ (kval < 0);
                kmag_next = (stp_reg[axis_reg] == 2'sd0) ? '0 :
                            hgrw_pkg::KM_W'(kval < 0 ? -kval : kval);
            end
            hgrw_pkg::ST_MKLO: plo_next = prod;
            hgrw_pkg::ST_MKHI: phi_next = prod;
            hgrw_pkg::ST_APPLY: begin
                crs_next[axis_reg] = hgrw_pkg::sat_inf(kneg_reg ? crs_reg[axis_reg] - mterm
                                                                : crs_reg[axis_reg] + mterm);
                axis_next = 1'b1;
                dist_next = '0;
                cnt_next  = '0;
            end
            hgrw_pkg::ST_WALK: begin
                if (walk_go) begin
                    if (take_x) begin
                        cell_next[0] = x_nx;
                        crs_next[0]  = hgrw_pkg::sat_inf(crs_reg[0] + inc_reg[0]);
                    end else begin
                        cell_next[1] = z_nx;
                        crs_next[1]  = hgrw_pkg::sat_inf(crs_reg[1] + inc_reg[1]);
                    end
                    dist_next     = dout;
                    cnt_next      = cnt_reg + 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = stop || (cnt_reg == hgrw_pkg::CNT_LAST);
                    m_tdata_next  = {hgrw_pkg::clamp_dist(dout),
                                     hgrw_pkg::clamp_dist(dist_reg),
                                     5'($unsigned(cell_reg[1])),
                                     5'($unsigned(cell_reg[0]))};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hgrw_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            offx_reg     <= '0;
            offz_reg     <= '0;
            cs_reg       <= 20'd65536;
            gw_reg       <= 6'd32;
            gd_reg       <= 6'd32;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    hgrw_pkg::REG_OFFSET_X:   offx_reg <= $signed(cfg_data);
                    hgrw_pkg::REG_OFFSET_Z:   offz_reg <= $signed(cfg_data);
                    hgrw_pkg::REG_CELL_SCALE: cs_reg   <= cfg_data[19:0];
                    hgrw_pkg::REG_GRID_WIDTH: gw_reg   <= cfg_data[5:0];
                    hgrw_pkg::REG_GRID_DEPTH: gd_reg   <= cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
        end
        sumx_reg <= sumx_next;
        sumz_reg <= sumz_next;
        dx_reg   <= dx_next;
        dz_reg   <= dz_next;
        px_reg   <= px_next;
        pz_reg   <= pz_next;
        ax_reg   <= ax_next;
        az_reg   <= az_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        it_reg   <= it_next;
        flat_reg <= flat_next;
        axis_reg <= axis_next;
        inc_reg  <= inc_next;
        crs_reg  <= crs_next;
        stp_reg  <= stp_next;
        cell_reg <= cell_next;
        kmag_reg <= kmag_next;
        kneg_reg <= kneg_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        dist_reg <= dist_next;
        cnt_reg  <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `HGRW_ASSERT_SAME(a_div_idle_on_start, div_start, !div_busy)
    `HGRW_ASSERT_NEXT(a_last_at_cap, walk_go && cnt_reg == hgrw_pkg::CNT_LAST, m_tlast)
    `HGRW_ASSERT_SAME(a_cell_in_grid, m_tvalid,
        ({27'd0, m_tdata[4:0]} <= 32'(w_eff) - 32'd2) &&
        ({27'd0, m_tdata[9:5]} <= 32'(d_eff) - 32'd2))

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for heightfield_grid_ray_walk_unit: segments are walked
// through the cell grid and every emitted cell is checked against a local predictor.
// Depends on hgrw_pkg and the RTL top level.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] end_z, end_y, end_x, begin_z, begin_y, begin_x;
    } segment_t;

    typedef struct packed {
        logic [4:0]  cell_x;
        logic [4:0]  cell_z;
        logic [30:0] enter_dist;
        logic [30:0] exit_dist;
        logic        last;
    } cell_t;

    localparam longint INF = 64'sh2000_0000_0000_0000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    heightfield_grid_ray_walk_unit u_top (.*);

    always #1 aclk = ~aclk;

    // grid settings as seen by the predictor
    logic [31:0] g_off_x = 0, g_off_z = 0;
    logic [19:0] g_scale = 20'd65536;
    logic [5:0]  g_width = 6'd32, g_depth = 6'd32;

    segment_t seg_queue[$];
    cell_t    cell_queue[$];
    int       n_errors = 0;
    int       idle_pct = 24;
    bit       hold_sink = 1'b0;
    bit       hold_start = 1'b0;
    bit       hold_done = 1'b0;
    // s_ready_seen records whether the word on offer was taken at the last rising edge
    logic     s_ready_seen = 1'b0;

    task automatic report(input string msg);
        $display("tb: mismatch %s", msg);
        n_errors++;
    endtask

    function automatic longint satq(input longint v);
        if (v > INF) return INF;
        if (v < -INF) return -INF;
        return v;
    endfunction

    function automatic longint satmul(input longint a, input longint k);
        longint mk;
        longint m;
        mk = k < 0 ? -k : k;
        if (k == 0 || a == 0) return 0;
        if (a > INF / mk) m = INF;
        else m = a * mk;
        return k < 0 ? -m : m;
    endfunction

    function automatic longint floor32(input longint p);
        if (p >= 0) return p >>> 32;
        return -longint'((longint'(-p) + 64'hFFFF_FFFF) >> 32);
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clampi(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic lane_setup(input longint pos, input longint dlt, input longint unsigned flat,
                              input longint size, output longint stp, output longint inc,
                              output longint crs, output longint cell_o);
        longint unsigned mag, frac, d;
        longint fc, st;
        mag = longint'(dlt < 0 ? -dlt : dlt) >> 16;
        frac = pos & 64'hFFFF_FFFF;
        fc = floor32(pos);
        if (mag == 0) begin
            stp = 0;
            inc = INF;
            crs = INF;
        end else begin
            stp = dlt > 0 ? 1 : -1;
            inc = (flat << 16) / mag;
            if (stp == 1) d = frac != 0 ? (64'd1 << 32) - frac : 0;
            else d = frac;
            crs = ((d >> 16) * flat) / mag;
        end
        if (crs == 0) begin
            crs = satq(crs + inc);
            if (stp == -1) fc -= 1;
        end
        st = clampi(fc, 0, size - 2);
        crs = satq(crs + satmul(inc, stp * (st - fc)));
        cell_o = st;
    endtask

    task automatic walk_segment(input segment_t sg);
        longint bx, bz, dx, dy, dz, cs, w, dp, px, pz, dxc, dzc;
        longint sx, sz, incx, incz, crx, crz, x, z, cx, cz, prev, run_dist, flen;
        longint unsigned ax, az, m, flat;
        int s, count;
        bit stop;
        cell_t c;
        bx = longint'($signed(sg.begin_x));
        bz = longint'($signed(sg.begin_z));
        dx = longint'($signed(sg.end_x)) - bx;
        dy = longint'($signed(sg.end_y)) - longint'($signed(sg.begin_y));
        dz = longint'($signed(sg.end_z)) - bz;
        if (dx == 0 && dy == 0 && dz == 0) return;
        cs = longint'(g_scale);
        w = clampi(longint'(g_width), 2, 32);
        dp = clampi(longint'(g_depth), 2, 32);
        px = (bx + longint'($signed(g_off_x))) * cs;
        pz = (bz + longint'($signed(g_off_z))) * cs;
        dxc = dx * cs;
        dzc = dz * cs;
        ax = longint'(dxc < 0 ? -dxc : dxc) >> 16;
        az = longint'(dzc < 0 ? -dzc : dzc) >> 16;
        m = ax > az ? ax : az;
        s = 0;
        while ((m >> s) >= (64'd1 << 31)) s++;
        flat = int_root((ax >> s) * (ax >> s) + (az >> s) * (az >> s)) << s;
        flen = flat;
        lane_setup(px, dxc, flat, w, sx, incx, crx, x);
        lane_setup(pz, dzc, flat, dp, sz, incz, crz, z);
        run_dist = 0;
        count = 0;
        while (count < 64) begin
            cx = x;
            cz = z;
            stop = 1'b0;
            prev = run_dist;
            if (crx < crz) begin
                x += sx;
                run_dist = crx;
                crx = satq(crx + incx);
            end else begin
                z += sz;
                run_dist = crz;
                crz = satq(crz + incz);
            end
            if (run_dist > flen) begin
                run_dist = flen;
                stop = 1'b1;
            end else if (x < 0 || z < 0 || x >= w - 1 || z >= dp - 1) begin
                stop = 1'b1;
            end
            c.cell_x = cx[4:0];
            c.cell_z = cz[4:0];
            c.enter_dist = 31'(clampi(prev, 0, 64'h7FFF_FFFF));
            c.exit_dist = 31'(clampi(run_dist, 0, 64'h7FFF_FFFF));
            c.last = stop || count == 63;
            cell_queue.push_back(c);
            count++;
            if (stop) break;
        end
    endtask

    // driver: advance on acceptance, predict at the same edge
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_ready_seen)) begin
            if (seg_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tdata <= seg_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !hold_sink && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        s_ready_seen <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            walk_segment(segment_t'(s_tdata));
        end
    end

    // monitor
    always @(posedge aclk) begin
        cell_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[71:0] >> 0, 1'b0};
            got.cell_x = m_tdata[4:0];
            got.cell_z = m_tdata[9:5];
            got.enter_dist = m_tdata[40:10];
            got.exit_dist = m_tdata[71:41];
            got.last = m_tlast;
            if (cell_queue.size() == 0) begin
                report($sformatf("unexpected cell %h", m_tdata));
            end else begin
                want = cell_queue.pop_front();
                if (got.cell_x !== want.cell_x)
                    report($sformatf("cell_x %0d want %0d", got.cell_x, want.cell_x));
                if (got.cell_z !== want.cell_z)
                    report($sformatf("cell_z %0d want %0d", got.cell_z, want.cell_z));
                if (got.enter_dist !== want.enter_dist)
                    report($sformatf("enter %h want %h", got.enter_dist, want.enter_dist));
                if (got.exit_dist !== want.exit_dist)
                    report($sformatf("exit %h want %h", got.exit_dist, want.exit_dist));
                if (got.last !== want.last)
                    report($sformatf("last %b want %b", got.last, want.last));
            end
        end
    end

    // hold off the sink for a long stretch once asked
    initial begin
        wait (hold_start);
        hold_sink = 1'b1;
        repeat (3000) @(posedge aclk);
        hold_sink = 1'b0;
        hold_done = 1'b1;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            hgrw_pkg::REG_OFFSET_X:   g_off_x = val;
            hgrw_pkg::REG_OFFSET_Z:   g_off_z = val;
            hgrw_pkg::REG_CELL_SCALE: g_scale = val[19:0];
            hgrw_pkg::REG_GRID_WIDTH: g_width = val[5:0];
            hgrw_pkg::REG_GRID_DEPTH: g_depth = val[5:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (seg_queue.size() != 0 || s_tvalid || cell_queue.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(input int span);
        int v;
        v = $urandom_range(2 * span) - span;
        return v;
    endfunction

    task automatic add_seg(input logic [31:0] a, b, c, d, e, f);
        segment_t sg;
        sg.begin_x = a; sg.begin_y = b; sg.begin_z = c;
        sg.end_x = d; sg.end_y = e; sg.end_z = f;
        seg_queue.push_back(sg);
    endtask

    task automatic random_segs(input int n);
        int span;
        repeat (n) begin
            span = ($urandom_range(9) == 0) ? 32'h7FFF_FFFF : 32 * 65536;
            if ($urandom_range(9) == 0)
                add_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(14) == 0)
                add_seg({16'($urandom_range(31)), 16'h0}, $urandom,
                        {16'($urandom_range(31)), 16'h0},
                        {16'($urandom_range(31)), 16'h0}, $urandom,
                        {16'($urandom_range(31)), 16'h0});
            else
                add_seg(rand_coord(span) + 16 * 65536, $urandom, rand_coord(span) + 16 * 65536,
                        rand_coord(span) + 16 * 65536, $urandom, rand_coord(span) + 16 * 65536);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, vertical, zero length, integer starts, ties, outside grid
        add_seg(0, 0, 0, 0, 0, 0);
        add_seg(0, 0, 0, 0, 32'h10000, 0);
        add_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_seg(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000);
        add_seg(32'h20000, 0, 32'h20000, 32'h80000, 0, 32'h80000);
        add_seg(32'h80000, 0, 32'h80000, 32'h20000, 0, 32'h20000);
        add_seg(32'h18000, 0, 32'h30000, 32'h1F8000, 0, 32'h30000);
        add_seg(32'h1F8000, 0, 32'h48000, 32'h18000, 0, 32'h48000);
        add_seg(32'hFFF00000, 0, 32'hFFF00000, 32'h100000, 0, 32'h100000);
        add_seg(32'h300000, 0, 32'h300000, 32'h100000, 0, 32'h180000);
        add_seg(32'h8000, 0, 32'h8000, 32'h1F8000, 0, 32'h1F8000);
        drain();
        write_reg(hgrw_pkg::REG_OFFSET_X, 32'h8000_0000);
        write_reg(hgrw_pkg::REG_OFFSET_Z, 32'h7FFF_FFFF);
        write_reg(hgrw_pkg::REG_CELL_SCALE, 32'd1);
        write_reg(hgrw_pkg::REG_GRID_WIDTH, 32'd2);
        write_reg(hgrw_pkg::REG_GRID_DEPTH, 32'd2);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        random_segs(15);
        drain();
        write_reg(hgrw_pkg::REG_CELL_SCALE, 32'd0);
        add_seg(32'h10000, 0, 0, 32'h50000, 0, 32'h30000);
        drain();
        write_reg(hgrw_pkg::REG_OFFSET_X, 32'h0);
        write_reg(hgrw_pkg::REG_OFFSET_Z, 32'h0);
        write_reg(hgrw_pkg::REG_CELL_SCALE, 32'd655360);
        write_reg(hgrw_pkg::REG_GRID_WIDTH, 32'd63);
        write_reg(hgrw_pkg::REG_GRID_DEPTH, 32'd0);
        random_segs(30);
        drain();
        write_reg(hgrw_pkg::REG_CELL_SCALE, 32'hFFFFF);
        write_reg(hgrw_pkg::REG_GRID_WIDTH, 32'd32);
        write_reg(hgrw_pkg::REG_GRID_DEPTH, 32'd32);
        random_segs(20);
        drain();
        write_reg(hgrw_pkg::REG_CELL_SCALE, 32'd65536);
        write_reg(hgrw_pkg::REG_OFFSET_X, 32'hFFFF_0000);
        write_reg(hgrw_pkg::REG_OFFSET_Z, 32'h0001_8000);
        // long hold on the sink while segments keep coming
        hold_start = 1'b1;
        random_segs(20);
        wait (hold_done);
        idle_pct = 0;
        random_segs(40);
        drain();
        idle_pct = 24;
        write_reg(hgrw_pkg::REG_GRID_WIDTH, 32'd17);
        write_reg(hgrw_pkg::REG_GRID_DEPTH, 32'd9);
        write_reg(hgrw_pkg::REG_CELL_SCALE, 32'd131072);
        random_segs(120);
        drain();
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hgrw_pkg.sv
rtl/core/hgrw_div.sv
rtl/core/heightfield_grid_ray_walk_unit.sv
dv/testbench.sv
